// ===== design/dfs_maze_carver_unit_macros.svh =====
// assertion macros shared by the maze carver rtl
`ifndef DFS_MAZE_CARVER_UNIT_MACROS_SVH
`define DFS_MAZE_CARVER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dmc_pkg.sv =====
// shared types and constants of the maze carver
package dmc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROW1,
        ST_ROW2,
        ST_EVAL,
        ST_FIN
    } t_state;

    // item function code
    localparam logic FUNC_START = 1'b0;

    // result event codes
    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_MOVE  = 2'd1;
    localparam logic [1:0] EV_BACK  = 2'd2;
    localparam logic [1:0] EV_DONE  = 2'd3;

    // direction codes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    // number of trial orders; ranks above wrap
    localparam logic [4:0] ORDER_COUNT = 5'd24;

    // lexicographic permutations of the four directions, first trial in the top bits
    localparam logic [7:0] ORDER_TABLE [24] = '{
        8'b00_01_10_11, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_10_11_01,
        8'b00_11_01_10, 8'b00_11_10_01, 8'b01_00_10_11, 8'b01_00_11_10,
        8'b01_10_00_11, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_11_10_00,
        8'b10_00_01_11, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_01_11_00,
        8'b10_11_00_01, 8'b10_11_01_00, 8'b11_00_01_10, 8'b11_00_10_01,
        8'b11_01_00_10, 8'b11_01_10_00, 8'b11_10_00_01, 8'b11_10_01_00
    };

    // move decision handed from the direction picker to the sequencer
    typedef struct packed {
        logic       found;
        logic [1:0] dir;
    } t_pick;

endpackage

// ===== design/dmc_pick.sv =====
// direction picker: bounds and visited checks, first free jump in trial order
module dmc_pick #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int JUMP     = 2
) (
    input  logic [$clog2(MAX_ROWS)-1:0] i_top_row,
    input  logic [$clog2(MAX_COLS)-1:0] i_top_col,
    input  logic [$clog2(MAX_ROWS):0]   i_rows,
    input  logic [$clog2(MAX_COLS):0]   i_cols,
    input  logic [MAX_COLS-1:0]         i_word_up,
    input  logic [MAX_COLS-1:0]         i_word_mid,
    input  logic [MAX_COLS-1:0]         i_word_dn,
    input  logic [4:0]                  i_order_index,
    output dmc_pkg::t_pick              o_pick,
    output logic [$clog2(MAX_ROWS)-1:0] o_tgt_row,
    output logic [$clog2(MAX_COLS)-1:0] o_tgt_col,
    output logic [$clog2(MAX_ROWS)-1:0] o_wall_row,
    output logic [$clog2(MAX_COLS)-1:0] o_wall_col
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int XR = RW + 3;
    localparam int XC = CW + 3;

    logic signed [XR-1:0] rx;
    logic signed [XC-1:0] cx;
    logic signed [XR-1:0] rows_x;
    logic signed [XC-1:0] cols_x;
    logic signed [XR-1:0] nr [4];
    logic signed [XR-1:0] wr [4];
    logic signed [XC-1:0] nc [4];
    logic signed [XC-1:0] wc [4];
    logic [CW-1:0]        cidx [4];
    logic [3:0]           inb;
    logic [3:0]           vis;
    logic [3:0]           ok;
    logic [4:0]           ridx;
    logic [7:0]           perm;
    logic [1:0]           dk;
    dmc_pkg::t_pick       pick;

    // signed views of the top cell and grid size
    assign rx     = signed'({3'b000, i_top_row});
    assign cx     = signed'({3'b000, i_top_col});
    assign rows_x = signed'({2'b00, i_rows});
    assign cols_x = signed'({2'b00, i_cols});

    // jump targets and wall cells of all four directions
    always_comb begin
        nr[dmc_pkg::DIR_UP]    = rx - XR'(JUMP);
        wr[dmc_pkg::DIR_UP]    = rx - XR'(1);
        nc[dmc_pkg::DIR_UP]    = cx;
        wc[dmc_pkg::DIR_UP]    = cx;
        nr[dmc_pkg::DIR_DOWN]  = rx + XR'(JUMP);
        wr[dmc_pkg::DIR_DOWN]  = rx + XR'(1);
        nc[dmc_pkg::DIR_DOWN]  = cx;
        wc[dmc_pkg::DIR_DOWN]  = cx;
        nr[dmc_pkg::DIR_LEFT]  = rx;
        wr[dmc_pkg::DIR_LEFT]  = rx;
        nc[dmc_pkg::DIR_LEFT]  = cx - XC'(JUMP);
        wc[dmc_pkg::DIR_LEFT]  = cx - XC'(1);
        nr[dmc_pkg::DIR_RIGHT] = rx;
        wr[dmc_pkg::DIR_RIGHT] = rx;
        nc[dmc_pkg::DIR_RIGHT] = cx + XC'(JUMP);
        wc[dmc_pkg::DIR_RIGHT] = cx + XC'(1);
    end

    // in-bounds and not yet visited, per direction
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            inb[d]  = (nr[d] >= 0) && (nr[d] < rows_x) && (nc[d] >= 0) && (nc[d] < cols_x);
            cidx[d] = inb[d] ? nc[d][CW-1:0] : '0;
            case (2'(d))
                dmc_pkg::DIR_UP:   vis[d] = i_word_up[cidx[d]];
                dmc_pkg::DIR_DOWN: vis[d] = i_word_dn[cidx[d]];
                default:           vis[d] = i_word_mid[cidx[d]];
            endcase
            ok[d] = inb[d] & ~vis[d];
        end
    end

    // trial order lookup, ranks past the table wrap around
    assign ridx = (i_order_index >= dmc_pkg::ORDER_COUNT) ?
                  (i_order_index - dmc_pkg::ORDER_COUNT) : i_order_index;
    assign perm = dmc_pkg::ORDER_TABLE[ridx];

    // first acceptable direction wins: scan from last trial to first
    always_comb begin
        pick.found = 1'b0;
        pick.dir   = dmc_pkg::DIR_UP;
        dk         = dmc_pkg::DIR_UP;
        for (int k = 3; k >= 0; k--) begin
            dk = perm[7-2*k -: 2];
            if (ok[dk]) begin
                pick.found = 1'b1;
                pick.dir   = dk;
            end
        end
    end

    assign o_pick     = pick;
    assign o_tgt_row  = nr[pick.dir][RW-1:0];
    assign o_tgt_col  = nc[pick.dir][CW-1:0];
    assign o_wall_row = wr[pick.dir][RW-1:0];
    assign o_wall_col = wc[pick.dir][CW-1:0];

endmodule

// ===== design/dfs_maze_carver_unit.sv =====
// maze carver top level: sequencer, visited-row memory, path stack memory
//
// Depth-first maze carver. A step transaction reads the stack top, then
// ST_ROW1 and ST_ROW2 read the three visited rows it needs (the current row
// and the rows one jump above and below) from a row-wide memory with two read
// ports, and ST_EVAL picks the direction, writes the marked row and the stack
// back and loads the result register once it is free. A step on an empty
// stack goes through ST_FIN only. A start transaction runs a clearing pass
// over the visited memory, one row per cycle; the block accepts no item during
// the pass, configuration writes are taken at any time. A new item is accepted
// while a finished result still waits in the output register; grid size
// registers should only be written while idle.
module dfs_maze_carver_unit #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int JUMP        = 2,
    parameter int STACK_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [4:0] i_order_index,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_event_res,
    output logic [5:0] o_wall_row,
    output logic [5:0] o_wall_col,
    output logic [5:0] o_cell_row,
    output logic [5:0] o_cell_col,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data
);

`include "dfs_maze_carver_unit_macros.svh"

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int XR  = RW + 3;
    localparam int SW  = RW + CW;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int RDW = (RW + 1 > 7) ? RW + 1 : 7;
    localparam int CDW = (CW + 1 > 7) ? CW + 1 : 7;

    dmc_pkg::t_state r_state, n_state;

    logic [6:0]          r_grid_rows, r_grid_cols;
    logic [SCW-1:0]      r_count, n_count;
    logic [RW-1:0]       r_clr;
    logic [RW-1:0]       r_top_row;
    logic [CW-1:0]       r_top_col;
    logic [MAX_COLS-1:0] r_word_up;
    logic [4:0]          r_order;

    // memories and their registered read data
    logic [MAX_COLS-1:0] r_vis_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_vis_rd_a, r_vis_rd_b;
    logic [SW-1:0]       r_stk_mem [STACK_DEPTH];
    logic [SW-1:0]       r_stk_rd;

    // output register
    logic       r_o_valid;
    logic [1:0] r_o_event;
    logic [5:0] r_o_wall_row, r_o_wall_col, r_o_cell_row, r_o_cell_col;

    logic                accept_in, slot_free, emit;
    logic [1:0]          n_o_event;
    logic [5:0]          n_o_wall_row, n_o_wall_col, n_o_cell_row, n_o_cell_col;
    logic                vis_we;
    logic [RW-1:0]       vis_wa, vis_ra_a, vis_ra_b;
    logic [MAX_COLS-1:0] vis_wd, tgt_word;
    logic                stk_we;
    logic [SAW-1:0]      stk_wa, stk_ra;
    logic [SW-1:0]       stk_wd;
    logic [SCW-1:0]      cnt_m1;
    logic [RW-1:0]       stk_row, cur_row;
    logic [CW-1:0]       stk_col;
    logic signed [XR-1:0] row_x, up_x, dn_x;
    logic [RW-1:0]       up_addr, dn_addr;
    logic [RDW-1:0]      rows_w, rows_k;
    logic [CDW-1:0]      cols_w, cols_k;
    logic [RW:0]         rows_c;
    logic [CW:0]         cols_c;
    dmc_pkg::t_pick      pick;
    logic [RW-1:0]       tgt_row, wall_row;
    logic [CW-1:0]       tgt_col, wall_col;

    // handshake terms
    assign o_ready     = (r_state == dmc_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept_in   = i_valid & o_ready;
    assign slot_free   = ~r_o_valid | i_ready;

    // grid size clamped to 1..MAX
    always_comb begin
        rows_w = RDW'(r_grid_rows);
        cols_w = CDW'(r_grid_cols);
        if (rows_w == '0) begin
            rows_k = RDW'(1);
        end else if (rows_w > RDW'(MAX_ROWS)) begin
            rows_k = RDW'(MAX_ROWS);
        end else begin
            rows_k = rows_w;
        end
        if (cols_w == '0) begin
            cols_k = CDW'(1);
        end else if (cols_w > CDW'(MAX_COLS)) begin
            cols_k = CDW'(MAX_COLS);
        end else begin
            cols_k = cols_w;
        end
        rows_c = (RW + 1)'(rows_k);
        cols_c = (CW + 1)'(cols_k);
    end

    // visited row addresses around the current top
    assign stk_row = r_stk_rd[SW-1:CW];
    assign stk_col = r_stk_rd[CW-1:0];
    assign cur_row = (r_state == dmc_pkg::ST_ROW1) ? stk_row : r_top_row;
    assign row_x   = signed'({3'b000, cur_row});
    assign up_x    = row_x - XR'(JUMP);
    assign dn_x    = row_x + XR'(JUMP);
    assign up_addr = (up_x >= 0) ? up_x[RW-1:0] : '0;
    assign dn_addr = (dn_x < XR'(MAX_ROWS)) ? dn_x[RW-1:0] : '0;
    assign vis_ra_a = (r_state == dmc_pkg::ST_ROW1) ? up_addr : dn_addr;
    assign vis_ra_b = cur_row;

    // stack top address
    assign cnt_m1 = r_count - SCW'(1);
    assign stk_ra = cnt_m1[SAW-1:0];

    dmc_pick #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .JUMP     (JUMP)
    ) u_pick (
        .i_top_row     (r_top_row),
        .i_top_col     (r_top_col),
        .i_rows        (rows_c),
        .i_cols        (cols_c),
        .i_word_up     (r_word_up),
        .i_word_mid    (r_vis_rd_b),
        .i_word_dn     (r_vis_rd_a),
        .i_order_index (r_order),
        .o_pick        (pick),
        .o_tgt_row     (tgt_row),
        .o_tgt_col     (tgt_col),
        .o_wall_row    (wall_row),
        .o_wall_col    (wall_col)
    );

    // row word that holds the chosen target
    always_comb begin
        case (pick.dir)
            dmc_pkg::DIR_UP:   tgt_word = r_word_up;
            dmc_pkg::DIR_DOWN: tgt_word = r_vis_rd_a;
            default:           tgt_word = r_vis_rd_b;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmc_pkg::ST_IDLE: begin
                if (accept_in) begin
                    if (i_func == dmc_pkg::FUNC_START) begin
                        n_state = dmc_pkg::ST_CLEAR;
                    end else if (r_count == '0) begin
                        n_state = dmc_pkg::ST_FIN;
                    end else begin
                        n_state = dmc_pkg::ST_ROW1;
                    end
                end
            end
            dmc_pkg::ST_CLEAR: begin
                if (r_clr == '0 && slot_free) begin
                    n_state = dmc_pkg::ST_IDLE;
                end
            end
            dmc_pkg::ST_ROW1: n_state = dmc_pkg::ST_ROW2;
            dmc_pkg::ST_ROW2: n_state = dmc_pkg::ST_EVAL;
            dmc_pkg::ST_EVAL, dmc_pkg::ST_FIN: begin
                if (slot_free) begin
                    n_state = dmc_pkg::ST_IDLE;
                end
            end
            default: n_state = dmc_pkg::ST_IDLE;
        endcase
    end

    // memory writes, stack count and result per state
    always_comb begin
        n_count      = r_count;
        vis_we       = 1'b0;
        vis_wa       = '0;
        vis_wd       = '0;
        stk_we       = 1'b0;
        stk_wa       = '0;
        stk_wd       = '0;
        emit         = 1'b0;
        n_o_event    = dmc_pkg::EV_START;
        n_o_wall_row = '0;
        n_o_wall_col = '0;
        n_o_cell_row = '0;
        n_o_cell_col = '0;
        unique case (r_state)
            dmc_pkg::ST_IDLE: begin
                // start: origin becomes the only stack entry
                if (accept_in && i_func == dmc_pkg::FUNC_START) begin
                    stk_we  = 1'b1;
                    n_count = SCW'(1);
                end
            end
            dmc_pkg::ST_CLEAR: begin
                // clear rows from the last row down to row zero, row zero keeps the origin marked
                vis_we = 1'b1;
                vis_wa = r_clr;
                vis_wd = (r_clr == '0) ? MAX_COLS'(1) : '0;
                if (r_clr == '0 && slot_free) begin
                    emit = 1'b1;
                end
            end
            dmc_pkg::ST_EVAL: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (pick.found) begin
                        n_o_event    = dmc_pkg::EV_MOVE;
                        n_o_wall_row = 6'(wall_row);
                        n_o_wall_col = 6'(wall_col);
                        n_o_cell_row = 6'(tgt_row);
                        n_o_cell_col = 6'(tgt_col);
                        vis_we       = 1'b1;
                        vis_wa       = tgt_row;
                        vis_wd       = tgt_word | (MAX_COLS'(1) << tgt_col);
                        // push unless the stack is full
                        if (r_count < SCW'(STACK_DEPTH)) begin
                            stk_we  = 1'b1;
                            stk_wa  = r_count[SAW-1:0];
                            stk_wd  = {tgt_row, tgt_col};
                            n_count = r_count + SCW'(1);
                        end
                    end else begin
                        n_o_event = dmc_pkg::EV_BACK;
                        n_count   = cnt_m1;
                    end
                end
            end
            dmc_pkg::ST_FIN: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    n_o_event = dmc_pkg::EV_DONE;
                end
            end
            default: ;
        endcase
    end

    // visited row memory, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis_mem[vis_wa] <= vis_wd;
        end
        r_vis_rd_a <= r_vis_mem[vis_ra_a];
        r_vis_rd_b <= r_vis_mem[vis_ra_b];
    end

    // path stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= r_stk_mem[stk_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmc_pkg::ST_IDLE;
            r_count     <= '0;
            r_clr       <= '0;
            r_grid_rows <= 7'd64;
            r_grid_cols <= 7'd64;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (accept_in && i_func == dmc_pkg::FUNC_START) begin
                r_clr <= RW'(MAX_ROWS - 1);
            end else if (r_state == dmc_pkg::ST_CLEAR && r_clr != '0) begin
                r_clr <= r_clr - RW'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dmc_pkg::CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                    dmc_pkg::CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_order <= i_order_index;
        end
        if (r_state == dmc_pkg::ST_ROW1) begin
            r_top_row <= stk_row;
            r_top_col <= stk_col;
        end
        if (r_state == dmc_pkg::ST_ROW2) begin
            r_word_up <= r_vis_rd_a;
        end
        if (emit) begin
            r_o_event    <= n_o_event;
            r_o_wall_row <= n_o_wall_row;
            r_o_wall_col <= n_o_wall_col;
            r_o_cell_row <= n_o_cell_row;
            r_o_cell_col <= n_o_cell_col;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_event_res = r_o_event;
    assign o_wall_row  = r_o_wall_row;
    assign o_wall_col  = r_o_wall_col;
    assign o_cell_row  = r_o_cell_row;
    assign o_cell_col  = r_o_cell_col;

    // checks
    `DMC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, accept_in && i_func == dmc_pkg::FUNC_START, r_state == dmc_pkg::ST_CLEAR && r_count == SCW'(1), "start did not begin a clearing pass")
    `DMC_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= SCW'(STACK_DEPTH), "stack count past depth")
    `DMC_ASSERT_NEXT(a_back_pops, i_clk, i_rst_n, emit && n_o_event == dmc_pkg::EV_BACK, r_count == $past(r_count) - SCW'(1), "backtrack did not pop")
    `DMC_ASSERT_NEXT(a_move_pushes, i_clk, i_rst_n, emit && n_o_event == dmc_pkg::EV_MOVE && r_count < SCW'(STACK_DEPTH), r_count == $past(r_count) + SCW'(1), "move did not push")

endmodule

// ===== dv/tb_dfs_maze_carver_unit.sv =====
// self-checking testbench for the depth-first maze carver: directed table then random mazes
module tb_dfs_maze_carver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS       = 64;
    localparam int MAX_COLS       = 64;
    localparam int JUMP           = 2;
    localparam int STACK_DEPTH    = 1024;
    localparam int ITEMS          = 2000;
    localparam int CALM_ITEMS     = 250;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    localparam logic FUNC_STEP = 1'b1;

    // one carving result as seen on the output ports
    typedef struct packed {
        logic [1:0] ev;
        logic [5:0] wall_row;
        logic [5:0] wall_col;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
    } t_maze_res;

    localparam t_maze_res RES_NONE  = '0;
    localparam t_maze_res RES_START = '{dmc_pkg::EV_START, 6'd0, 6'd0, 6'd0, 6'd0};
    localparam t_maze_res RES_BACK  = '{dmc_pkg::EV_BACK, 6'd0, 6'd0, 6'd0, 6'd0};
    localparam t_maze_res RES_DONE  = '{dmc_pkg::EV_DONE, 6'd0, 6'd0, 6'd0, 6'd0};

    // directed table row: either a register write or an item
    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic       cfg_idx;
        logic [6:0] cfg_data;
        logic       func;
        logic [4:0] ord;
        bit         typed;
        t_maze_res  want;
    } t_drow;

    localparam int DIR_ROWS = 29;

    t_drow dir_tab [DIR_ROWS] = '{
        // step before any start finds an empty stack
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd0, 1'b1, RES_DONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, dmc_pkg::FUNC_START, 5'd0, 1'b1, RES_START},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd23, 1'b0, RES_NONE},
        // ranks above the permutation count wrap
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd31, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd24, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd16, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd12, 1'b0, RES_NONE},
        // restart in the middle of a maze
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, dmc_pkg::FUNC_START, 5'd31, 1'b1, RES_START},
        // single-cell grid: nothing to carve
        '{ROW_CFG, dmc_pkg::CFG_GRID_ROWS, 7'd1, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_CFG, dmc_pkg::CFG_GRID_COLS, 7'd1, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, dmc_pkg::FUNC_START, 5'd0, 1'b1, RES_START},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd5, 1'b1, RES_BACK},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd18, 1'b1, RES_DONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd31, 1'b1, RES_DONE},
        // zero size acts as one, oversize clamps to the maximum
        '{ROW_CFG, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_CFG, dmc_pkg::CFG_GRID_COLS, 7'd127, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, dmc_pkg::FUNC_START, 5'd0, 1'b1, RES_START},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd9, 1'b0, RES_NONE},
        // reshape the grid under a live maze
        '{ROW_CFG, dmc_pkg::CFG_GRID_ROWS, 7'd127, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_CFG, dmc_pkg::CFG_GRID_COLS, 7'd0, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd2, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, dmc_pkg::FUNC_START, 5'd0, 1'b1, RES_START},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd6, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd20, 1'b0, RES_NONE},
        // grow it back and keep carving
        '{ROW_CFG, dmc_pkg::CFG_GRID_ROWS, 7'd64, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_CFG, dmc_pkg::CFG_GRID_COLS, 7'd64, FUNC_STEP, 5'd0, 1'b0, RES_NONE},
        '{ROW_ITEM, dmc_pkg::CFG_GRID_ROWS, 7'd0, FUNC_STEP, 5'd11, 1'b0, RES_NONE}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_func;
    logic [4:0] i_order_index;
    logic       o_valid;
    logic       i_ready;
    logic [1:0] o_event_res;
    logic [5:0] o_wall_row;
    logic [5:0] o_wall_col;
    logic [5:0] o_cell_row;
    logic [5:0] o_cell_col;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [6:0] i_cfg_data;

    dfs_maze_carver_unit #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .JUMP        (JUMP),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_order_index (i_order_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_event_res   (o_event_res),
        .o_wall_row    (o_wall_row),
        .o_wall_col    (o_wall_col),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // carver state mirrored by the testbench
    bit         cell_seen [MAX_ROWS * MAX_COLS];
    int         trail_row [STACK_DEPTH];
    int         trail_col [STACK_DEPTH];
    int         trail_len;
    logic [6:0] rows_reg;
    logic [6:0] cols_reg;

    t_maze_res  pending_res [$];
    int         n_errors;
    int         n_sent;
    bit         calm;
    bit         tx_gaps;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one carving step on the mirrored state
    function automatic t_maze_res carve_step(input logic func, input logic [4:0] ord);
        t_maze_res  res;
        int         rows;
        int         cols;
        int         r;
        int         c;
        int         dr;
        int         dc;
        int         nr;
        int         nc;
        int         rank;
        int         pick;
        int         left;
        logic [1:0] pool [4];
        logic [1:0] trial [4];
        int         fact [4];
        res  = '0;
        fact = '{6, 2, 1, 1};
        rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg));
        cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
        if (func == dmc_pkg::FUNC_START) begin
            foreach (cell_seen[i]) cell_seen[i] = 1'b0;
            trail_row[0] = 0;
            trail_col[0] = 0;
            trail_len    = 1;
            cell_seen[0] = 1'b1;
            res.ev       = dmc_pkg::EV_START;
            return res;
        end
        if (trail_len == 0) begin
            res.ev = dmc_pkg::EV_DONE;
            return res;
        end
        // unrank the trial order
        pool = '{dmc_pkg::DIR_UP, dmc_pkg::DIR_DOWN,
                 dmc_pkg::DIR_LEFT, dmc_pkg::DIR_RIGHT};
        rank = ord % dmc_pkg::ORDER_COUNT;
        left = 4;
        for (int k = 0; k < 4; k++) begin
            pick = rank / fact[k];
            rank = rank % fact[k];
            if (pick >= left) pick = left - 1;
            trial[k] = pool[pick];
            for (int m = pick; m + 1 < left; m++) pool[m] = pool[m + 1];
            left--;
        end
        r = trail_row[trail_len - 1];
        c = trail_col[trail_len - 1];
        for (int k = 0; k < 4; k++) begin
            case (trial[k])
                dmc_pkg::DIR_UP: begin
                    dr = -1;
                    dc = 0;
                end
                dmc_pkg::DIR_DOWN: begin
                    dr = 1;
                    dc = 0;
                end
                dmc_pkg::DIR_LEFT: begin
                    dr = 0;
                    dc = -1;
                end
                default: begin
                    dr = 0;
                    dc = 1;
                end
            endcase
            nr = r + dr * JUMP;
            nc = c + dc * JUMP;
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            if (cell_seen[nr * MAX_COLS + nc]) continue;
            cell_seen[nr * MAX_COLS + nc] = 1'b1;
            // a full stack still carves but drops the push
            if (trail_len < STACK_DEPTH) begin
                trail_row[trail_len] = nr;
                trail_col[trail_len] = nc;
                trail_len++;
            end
            res.ev       = dmc_pkg::EV_MOVE;
            res.wall_row = 6'(r + dr);
            res.wall_col = 6'(c + dc);
            res.cell_row = 6'(nr);
            res.cell_col = 6'(nc);
            return res;
        end
        trail_len--;
        res.ev = dmc_pkg::EV_BACK;
        return res;
    endfunction

    // grid size pick, mostly small so mazes complete
    function automatic logic [6:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return 7'd0;
            1:       return 7'd64;
            2:       return 7'($urandom_range(65, 127));
            3, 4:    return 7'($urandom_range(13, 64));
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic flag_error(input string msg);
        $display("tb: mismatch: %s", msg);
        n_errors++;
    endtask

    // offer one item, predict its result once the transaction completes
    task automatic push_item(input logic func, input logic [4:0] ord, input bit typed,
                             input t_maze_res want, output t_maze_res outcome);
        t_maze_res predicted;
        if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_order_index <= ord;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predicted = carve_step(func, ord);
        pending_res.insert(pending_res.size(), typed ? want : predicted);
        outcome = predicted;
        n_sent++;
        calm = (n_sent >= ITEMS - CALM_ITEMS);
    endtask

    // register write; valid stays up when another write follows
    task automatic cfg_write(input logic idx, input logic [6:0] data, input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == dmc_pkg::CFG_GRID_ROWS) rows_reg = data;
        else cols_reg = data;
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_block();
        i_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        t_maze_res outcome;
        int        step_cap;
        int        tail;
        logic      func;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_func        <= 1'b0;
        i_order_index <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= dmc_pkg::CFG_GRID_ROWS;
        i_cfg_data    <= '0;
        foreach (cell_seen[i]) cell_seen[i] = 1'b0;
        trail_len = 0;
        rows_reg  = 7'd64;
        cols_reg  = 7'd64;
        n_errors  = 0;
        n_sent    = 0;
        calm      = 1'b0;
        tx_gaps   = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                drain_block();
                cfg_write(dir_tab[i].cfg_idx, dir_tab[i].cfg_data,
                          i + 1 < DIR_ROWS && dir_tab[i + 1].kind == ROW_CFG);
            end else begin
                push_item(dir_tab[i].func, dir_tab[i].ord, dir_tab[i].typed,
                          dir_tab[i].want, outcome);
            end
        end

        // random mazes, sometimes resized without a restart
        while (n_sent < ITEMS) begin
            tx_gaps = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) != 0) begin
                drain_block();
                case ($urandom_range(0, 2))
                    0: cfg_write(dmc_pkg::CFG_GRID_ROWS, pick_dim(), 1'b0);
                    1: cfg_write(dmc_pkg::CFG_GRID_COLS, pick_dim(), 1'b0);
                    default: begin
                        cfg_write(dmc_pkg::CFG_GRID_ROWS, pick_dim(), 1'b1);
                        cfg_write(dmc_pkg::CFG_GRID_COLS, pick_dim(), 1'b0);
                    end
                endcase
            end
            if ($urandom_range(0, 5) != 0)
                push_item(dmc_pkg::FUNC_START, 5'($urandom_range(0, 31)), 1'b0, RES_NONE,
                          outcome);
            step_cap = $urandom_range(30, 400);
            tail     = $urandom_range(0, 2);
            for (int s = 0; s < step_cap && n_sent < ITEMS; s++) begin
                func = ($urandom_range(0, 49) == 0) ? dmc_pkg::FUNC_START : FUNC_STEP;
                push_item(func, 5'($urandom_range(0, 31)), 1'b0, RES_NONE, outcome);
                if (outcome.ev == dmc_pkg::EV_DONE) begin
                    if (tail == 0) break;
                    tail--;
                end
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_res.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: random stalls plus long hold-offs that back up the block
    initial begin : result_sink
        int rx_done;
        int hold_mark;
        int mode_left;
        int stall_pct;
        rx_done   = 0;
        hold_mark = 150;
        mode_left = 0;
        stall_pct = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready === 1'b1) rx_done++;
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 40;
                endcase
                mode_left = 100;
            end
            mode_left--;
            if (!calm && rx_done >= hold_mark) begin
                hold_mark += 700;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_maze_res want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_res.size() == 0) begin
                flag_error("result arrived with nothing expected");
            end else begin
                want = pending_res.pop_front();
                if (o_event_res !== want.ev)
                    flag_error($sformatf("event_res got %0d expected %0d",
                                         o_event_res, want.ev));
                if (o_wall_row !== want.wall_row)
                    flag_error($sformatf("wall_row got %0d expected %0d",
                                         o_wall_row, want.wall_row));
                if (o_wall_col !== want.wall_col)
                    flag_error($sformatf("wall_col got %0d expected %0d",
                                         o_wall_col, want.wall_col));
                if (o_cell_row !== want.cell_row)
                    flag_error($sformatf("cell_row got %0d expected %0d",
                                         o_cell_row, want.cell_row));
                if (o_cell_col !== want.cell_col)
                    flag_error($sformatf("cell_col got %0d expected %0d",
                                         o_cell_col, want.cell_col));
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        int quiet_run;
        quiet_run = 0;
        while (quiet_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_ready === 1'b1) ||
                (o_valid === 1'b1 && i_ready === 1'b1) ||
                (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1))
                quiet_run = 0;
            else
                quiet_run++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
